/* hw/rtl/slsr_pkg.sv */
// ----------------------------------------------------------------------------
// slsr_pkg
// Types, codes and helpers shared by the linear speed ramp blocks.
// ----------------------------------------------------------------------------
package slsr_pkg;

    localparam int unsigned TIMER_HZ_DEF      = 1000000;
    localparam int unsigned STEPS_PER_REV_DEF = 200;

    localparam int unsigned DVD_W = 64;
    localparam int unsigned DVS_W = 32;
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 20;
    localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
    localparam int unsigned ROOT_W = 17;

    localparam logic [1:0] CMD_MOVE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_DECEL = 2'd2,
        PH_RUN   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] steps;
        logic [15:0]        accel;
        logic [15:0]        decel;
        logic [15:0]        speed;
    } t_in_word;

    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic [31:0] timer_load;
        logic        timer_running;
        logic        driver_enabled;
        logic [1:0]  ramp_phase;
        logic        error;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic             half;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] x;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

/* hw/rtl/slsr_div.sv */
// ----------------------------------------------------------------------------
// slsr_div
// Restoring divider, one quotient bit per cycle, 64 or 32 iterations.
// ----------------------------------------------------------------------------
module slsr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slsr_pkg::t_div_req i_req,
    output slsr_pkg::t_div_rsp o_rsp
);
    import slsr_pkg::*;

    logic [DVD_W-1:0] r_q,    n_q;
    logic [DVS_W-1:0] r_rem,  n_rem;
    logic [DVS_W-1:0] r_dvs,  n_dvs;
    logic [6:0]       r_cnt,  n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DVS_W:0]   trial;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_q[DVD_W-1]};
        ge     = trial >= {1'b0, r_dvs};
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_dvs  = i_req.divisor;
            n_rem  = '0;
            n_busy = 1'b1;
            if (i_req.half) begin
                n_q   = {i_req.dividend[31:0], 32'd0};
                n_cnt = 7'd32;
            end else begin
                n_q   = i_req.dividend;
                n_cnt = 7'd64;
            end
        end else if (r_busy) begin
            n_rem = ge ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
            n_q   = {r_q[DVD_W-2:0], ge};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

/* hw/rtl/slsr_sqrt.sv */
// ----------------------------------------------------------------------------
// slsr_sqrt
// Rounded integer square root, two operand bits per cycle.
// ----------------------------------------------------------------------------
module slsr_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slsr_pkg::t_sqrt_req i_req,
    output slsr_pkg::t_sqrt_rsp o_rsp
);
    import slsr_pkg::*;

    logic [31:0]       r_rem,  n_rem;
    logic [31:0]       r_res,  n_res;
    logic [31:0]       r_bit,  n_bit;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [32:0]       sum;
    logic              take;

    always_comb begin
        sum    = {1'b0, r_res} + {1'b0, r_bit};
        take   = sum <= {1'b0, r_rem};
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_root = r_root;
        if (i_req.start) begin
            n_rem  = i_req.x;
            n_res  = '0;
            n_bit  = 32'h4000_0000;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_bit != '0) begin
                n_rem = take ? r_rem - sum[31:0] : r_rem;
                n_res = (r_res >> 1) + (take ? r_bit : 32'd0);
                n_bit = r_bit >> 2;
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_root = (r_res < r_rem) ? ROOT_W'(r_res + 32'd1) : ROOT_W'(r_res);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_root <= n_root;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

/* hw/rtl/stepper_linear_speed_ramp.sv */
// ----------------------------------------------------------------------------
// stepper_linear_speed_ramp
// Trapezoidal stepper ramp generator with serial divide and square root.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall / i_in_word carry move, tick and
// stop commands. Output channel: o_out_valid / i_out_stall / o_out_word
// carry one result word per command.
// A word is taken while the sequencer is idle; the block works on one
// command at a time. Stop and ignored commands go straight to the output
// register. A tick passes the tick step and, when the delay recurrence runs,
// its 32-bit serial division; a single-step move takes the same path.
// A move runs five to seven full-width serial divisions, a square root and,
// when it starts accelerating, the recurrence division; all divisions use
// the shared one-bit-per-cycle divider.
// A finished result sits in the output register while the next command is
// taken; when the receiver stalls and a new result is ready, the sequencer
// holds it until the register frees.
// Reset clears the ramp state to stop, the driver and timer off, and
// empties the output register.
// ----------------------------------------------------------------------------
module stepper_linear_speed_ramp #(
    parameter int unsigned TIMER_HZ      = slsr_pkg::TIMER_HZ_DEF,
    parameter int unsigned STEPS_PER_REV = slsr_pkg::STEPS_PER_REV_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  slsr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output slsr_pkg::t_out_word o_out_word
);
    import slsr_pkg::*;

    localparam logic [63:0] K_AT100 =
        64'd628318 * 64'(TIMER_HZ) / (64'd1000 * 64'(STEPS_PER_REV));
    localparam logic [63:0] K_TF148 = 64'(TIMER_HZ) * 64'd676 / 64'd100000;
    localparam logic [63:0] K_ASQ = 64'd125663600000 / 64'(STEPS_PER_REV);
    localparam logic [63:0] K_A20000 = 64'd1256636 / (64'd10 * 64'(STEPS_PER_REV));
    localparam logic [DVS_W-1:0] HUNDRED = DVS_W'(100);

    typedef enum logic [17:0] {
        ST_IDLE     = 18'h00001,
        ST_FLOOR    = 18'h00002,
        ST_SQOP     = 18'h00004,
        ST_ROOT     = 18'h00008,
        ST_MUL_DLY  = 18'h00010,
        ST_DLY      = 18'h00020,
        ST_MUL_DIVV = 18'h00040,
        ST_DIVV     = 18'h00080,
        ST_MUL_MLIM = 18'h00100,
        ST_MLIM     = 18'h00200,
        ST_MUL_ALIM = 18'h00400,
        ST_ALIM     = 18'h00800,
        ST_MUL_DCI  = 18'h01000,
        ST_DCI      = 18'h02000,
        ST_SETUP    = 18'h04000,
        ST_TICK     = 18'h08000,
        ST_RECUR    = 18'h10000,
        ST_FIN      = 18'h20000
    } t_state;

    t_state      r_state, n_state;
    logic        r_wait, n_wait;
    logic        r_move, n_move;
    logic        r_pulse, n_pulse;
    logic [31:0] r_load, n_load;
    logic        r_err, n_err;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_dec, n_dec;
    logic [15:0] r_spd, n_spd;
    logic [31:0] r_mag, n_mag;
    logic [31:0] r_tmp, n_tmp;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [31:0] r_divv, n_divv;
    logic [31:0] r_mlim, n_mlim;

    t_phase      r_phase, n_phase;
    logic        r_dir, n_dir;
    logic [31:0] r_cur, n_cur;
    logic [31:0] r_dbeg, n_dbeg;
    logic [31:0] r_dci, n_dci;
    logic [31:0] r_floor, n_floor;
    logic [31:0] r_rcnt, n_rcnt;
    logic [31:0] r_cruise, n_cruise;
    logic [31:0] r_sdone, n_sdone;
    logic [31:0] r_rem, n_rem;
    logic        r_drv, n_drv;
    logic        r_tmr, n_tmr;

    logic        r_ovalid, n_ovalid;
    t_out_word   r_oword, n_oword;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_sqrt_req   sqrt_req;
    t_sqrt_rsp   sqrt_rsp;

    logic               in_fire;
    logic [31:0]        in_mag;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [31:0]        a_raw, b_raw, a_abs, b_abs;
    logic [31:0]        q_s, r_s, nd;
    logic [31:0]        q32, alim, dci_fix, rcnt_inc, sdone_inc;

    slsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    slsr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    assign in_fire = i_in_valid && !o_in_stall;
    assign in_mag  = i_in_word.steps[31] ? 32'd0 - 32'(i_in_word.steps)
                                         : 32'(i_in_word.steps);

    assign a_raw = {r_cur[30:0], 1'b0} + r_rem;
    assign b_raw = {r_rcnt[29:0], 2'b00} + 32'd1;
    assign a_abs = a_raw[31] ? 32'd0 - a_raw : a_raw;
    assign b_abs = b_raw[31] ? 32'd0 - b_raw : b_raw;
    assign q32   = div_rsp.quot[31:0];
    assign q_s   = (a_raw[31] ^ b_raw[31]) ? 32'd0 - q32 : q32;
    assign r_s   = a_raw[31] ? 32'd0 - div_rsp.rem : div_rsp.rem;
    assign nd    = r_cur - q_s;
    assign alim  = (q32 == '0) ? 32'd1 : q32;
    assign dci_fix   = (r_dci == '0) ? 32'hFFFF_FFFF : r_dci;
    assign rcnt_inc  = r_rcnt + 32'd1;
    assign sdone_inc = r_sdone + 32'd1;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.half     = 1'b0;
        div_req.dividend = 64'(r_prod);
        div_req.divisor  = HUNDRED;
        mul_a            = '0;
        mul_b            = '0;
        unique case (r_state)
            ST_FLOOR: begin
                div_req.dividend = K_AT100;
                div_req.divisor  = DVS_W'(r_spd);
            end
            ST_SQOP: begin
                div_req.dividend = K_ASQ;
                div_req.divisor  = DVS_W'(r_acc);
            end
            ST_MLIM:  div_req.divisor = r_divv;
            ST_ALIM:  div_req.divisor = DVS_W'({1'b0, r_acc} + {1'b0, r_dec});
            ST_DCI:   div_req.divisor = DVS_W'(r_dec);
            ST_RECUR: begin
                div_req.half     = 1'b1;
                div_req.dividend = 64'(a_abs);
                div_req.divisor  = b_abs;
            end
            ST_MUL_DLY: begin
                mul_a = MUL_A_W'(K_TF148);
                mul_b = MUL_B_W'(r_root);
            end
            ST_MUL_DIVV: begin
                mul_a = MUL_A_W'(r_acc);
                mul_b = MUL_B_W'(K_A20000);
            end
            ST_MUL_MLIM: begin
                mul_a = MUL_A_W'(r_spd);
                mul_b = MUL_B_W'(r_spd);
            end
            ST_MUL_ALIM: begin
                mul_a = r_mag;
                mul_b = MUL_B_W'(r_dec);
            end
            ST_MUL_DCI: begin
                mul_a = r_mlim;
                mul_b = MUL_B_W'(r_acc);
            end
            default: ;
        endcase
        case (r_state)
            ST_FLOOR, ST_SQOP, ST_DLY, ST_DIVV, ST_ALIM, ST_DCI, ST_RECUR:
                div_req.start = !r_wait;
            ST_MLIM:
                div_req.start = !r_wait && (r_divv != '0);
            default: ;
        endcase
        sqrt_req.start = (r_state == ST_ROOT) && !r_wait;
        sqrt_req.x     = r_tmp;
    end

    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_move   = r_move;
        n_pulse  = r_pulse;
        n_load   = r_load;
        n_err    = r_err;
        n_acc    = r_acc;
        n_dec    = r_dec;
        n_spd    = r_spd;
        n_mag    = r_mag;
        n_tmp    = r_tmp;
        n_root   = r_root;
        n_prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
        n_divv   = r_divv;
        n_mlim   = r_mlim;
        n_phase  = r_phase;
        n_dir    = r_dir;
        n_cur    = r_cur;
        n_dbeg   = r_dbeg;
        n_dci    = r_dci;
        n_floor  = r_floor;
        n_rcnt   = r_rcnt;
        n_cruise = r_cruise;
        n_sdone  = r_sdone;
        n_rem    = r_rem;
        n_drv    = r_drv;
        n_tmr    = r_tmr;
        n_ovalid = r_ovalid && i_out_stall;
        n_oword  = r_oword;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_pulse = 1'b0;
                    n_load  = '0;
                    n_err   = 1'b0;
                    n_move  = 1'b0;
                    n_acc   = i_in_word.accel;
                    n_dec   = i_in_word.decel;
                    n_spd   = i_in_word.speed;
                    n_mag   = in_mag;
                    n_state = ST_FIN;
                    case (i_in_word.cmd)
                        CMD_MOVE: begin
                            if (i_in_word.accel == '0 || i_in_word.decel == '0 ||
                                i_in_word.speed == '0) begin
                                n_err = 1'b1;
                            end else begin
                                n_dir  = i_in_word.steps[31];
                                n_drv  = 1'b1;
                                n_move = in_mag != '0;
                                if (in_mag == 32'd1) begin
                                    n_rcnt  = 32'hFFFF_FFFF;
                                    n_phase = PH_DECEL;
                                    n_cur   = 32'd1;
                                    n_state = ST_TICK;
                                end else if (in_mag != '0) begin
                                    n_state = ST_FLOOR;
                                end
                            end
                        end
                        CMD_TICK: n_state = ST_TICK;
                        CMD_STOP: n_phase = PH_STOP;
                        default: ;
                    endcase
                end
            end
            ST_FLOOR, ST_SQOP, ST_DLY, ST_DIVV, ST_ALIM, ST_DCI: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (div_rsp.done) begin
                    n_wait = 1'b0;
                    case (r_state)
                        ST_FLOOR: begin
                            n_floor = sat32(div_rsp.quot);
                            n_state = ST_SQOP;
                        end
                        ST_SQOP: begin
                            n_tmp   = sat32(div_rsp.quot);
                            n_state = ST_ROOT;
                        end
                        ST_DLY: begin
                            n_cur   = sat32(div_rsp.quot);
                            n_state = ST_MUL_DIVV;
                        end
                        ST_DIVV: begin
                            n_divv  = q32;
                            n_state = ST_MUL_MLIM;
                        end
                        ST_ALIM: begin
                            if (alim <= r_mlim) begin
                                n_dci   = alim - r_mag;
                                n_state = ST_SETUP;
                            end else begin
                                n_state = ST_MUL_DCI;
                            end
                        end
                        default: begin
                            n_dci   = 32'd0 - q32;
                            n_state = ST_SETUP;
                        end
                    endcase
                end
            end
            ST_ROOT: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (sqrt_rsp.done) begin
                    n_wait  = 1'b0;
                    n_root  = sqrt_rsp.root;
                    n_state = ST_MUL_DLY;
                end
            end
            ST_MUL_DLY:  n_state = ST_DLY;
            ST_MUL_DIVV: n_state = ST_DIVV;
            ST_MUL_MLIM: n_state = ST_MLIM;
            ST_MUL_ALIM: n_state = ST_ALIM;
            ST_MUL_DCI:  n_state = ST_DCI;
            ST_MLIM: begin
                if (r_divv == '0) begin
                    n_mlim  = 32'hFFFF_FFFF;
                    n_state = ST_MUL_ALIM;
                end else if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (div_rsp.done) begin
                    n_wait  = 1'b0;
                    n_mlim  = alim;
                    n_state = ST_MUL_ALIM;
                end
            end
            ST_SETUP: begin
                n_dci  = dci_fix;
                n_dbeg = r_mag + dci_fix;
                n_rcnt = '0;
                if (r_cur <= r_floor) begin
                    n_cur   = r_floor;
                    n_phase = PH_RUN;
                end else begin
                    n_phase = PH_ACCEL;
                end
                n_state = ST_TICK;
            end
            ST_TICK: begin
                n_load  = r_cur;
                n_pulse = r_phase != PH_STOP;
                n_sdone = sdone_inc;
                n_state = ST_FIN;
                unique case (r_phase)
                    PH_STOP: begin
                        n_sdone = '0;
                        n_rem   = '0;
                        n_tmr   = 1'b0;
                        n_drv   = 1'b0;
                        n_cur   = '0;
                    end
                    PH_RUN: begin
                        if (sdone_inc >= r_dbeg) begin
                            n_rcnt  = r_dci;
                            n_cur   = r_cruise;
                            n_phase = PH_DECEL;
                        end else begin
                            n_cur = r_floor;
                        end
                    end
                    PH_ACCEL: begin
                        n_rcnt  = rcnt_inc;
                        n_state = ST_RECUR;
                    end
                    default: n_state = ST_RECUR;
                endcase
            end
            ST_RECUR: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (div_rsp.done) begin
                    n_wait  = 1'b0;
                    n_state = ST_FIN;
                    n_cur   = nd;
                    n_rem   = r_s;
                    if (r_phase == PH_ACCEL) begin
                        if (r_sdone >= r_dbeg) begin
                            n_rcnt  = r_dci;
                            n_phase = PH_DECEL;
                        end else if (nd <= r_floor) begin
                            n_cruise = nd;
                            n_cur    = r_floor;
                            n_rem    = '0;
                            n_phase  = PH_RUN;
                        end
                    end else begin
                        n_rcnt = rcnt_inc;
                        if (!rcnt_inc[31]) begin
                            n_phase = PH_STOP;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid               = 1'b1;
                    n_oword.step_pulse     = r_pulse;
                    n_oword.direction      = r_dir;
                    n_oword.timer_load     = r_load;
                    n_oword.timer_running  = r_tmr | r_move;
                    n_oword.driver_enabled = r_drv;
                    n_oword.ramp_phase     = r_phase;
                    n_oword.error          = r_err;
                    n_tmr                  = r_tmr | r_move;
                    n_state                = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_phase  <= PH_STOP;
            r_dir    <= 1'b0;
            r_cur    <= '0;
            r_dbeg   <= '0;
            r_dci    <= '0;
            r_floor  <= '0;
            r_rcnt   <= '0;
            r_cruise <= '0;
            r_sdone  <= '0;
            r_rem    <= '0;
            r_drv    <= 1'b0;
            r_tmr    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
            r_phase  <= n_phase;
            r_dir    <= n_dir;
            r_cur    <= n_cur;
            r_dbeg   <= n_dbeg;
            r_dci    <= n_dci;
            r_floor  <= n_floor;
            r_rcnt   <= n_rcnt;
            r_cruise <= n_cruise;
            r_sdone  <= n_sdone;
            r_rem    <= n_rem;
            r_drv    <= n_drv;
            r_tmr    <= n_tmr;
        end
        r_move  <= n_move;
        r_pulse <= n_pulse;
        r_load  <= n_load;
        r_err   <= n_err;
        r_acc   <= n_acc;
        r_dec   <= n_dec;
        r_spd   <= n_spd;
        r_mag   <= n_mag;
        r_tmp   <= n_tmp;
        r_root  <= n_root;
        r_prod  <= n_prod;
        r_divv  <= n_divv;
        r_mlim  <= n_mlim;
        r_oword <= n_oword;
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    a_take_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE))
        else $error("accepted word did not start the sequencer");

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_FLOOR || r_state == ST_SQOP ||
                          r_state == ST_DLY || r_state == ST_DIVV ||
                          r_state == ST_MLIM || r_state == ST_ALIM ||
                          r_state == ST_DCI || r_state == ST_RECUR))
        else $error("divider finished outside a division step");

    a_err_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.error && o_out_word.step_pulse))
        else $error("rejected move issued a step");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives move, tick and stop words into the stepper ramp generator at random
// pace, predicts every result word with an internal ramp model and compares
// each output word as a whole against its prediction in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import slsr_pkg::*;

    localparam longint unsigned K_AT100  = 64'd628318 * 64'd1000000 / (64'd1000 * 64'd200);
    localparam longint unsigned K_TF148  = 64'd1000000 * 64'd676 / 64'd100000;
    localparam longint unsigned K_ASQ    = 64'd125663600000 / 64'd200;
    localparam longint unsigned K_A20000 = 64'd1256636 / (64'd10 * 64'd200);
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_word o_out_word;

    stepper_linear_speed_ramp DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
    );

    always #1 i_clk = ~i_clk;

    t_phase      rp_phase;
    logic        rp_dir, rp_drv, rp_tmr;
    logic [31:0] rp_delay, rp_dbegin, rp_dcount, rp_floor, rp_count, rp_cruise;
    logic [31:0] rp_done, rp_rem;

    t_out_word expected_words[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    function automatic logic [31:0] sat_u64(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] root_rounded(logic [31:0] x);
        longint unsigned rem, res, b;
        bit take;
        rem = x; res = 0; b = 64'h4000_0000;
        while (b != 0) begin
            take = (res + b) <= rem;
            if (take) rem -= res + b;
            res >>= 1;
            if (take) res += b;
            b >>= 2;
        end
        return (res < rem) ? res[31:0] + 1 : res[31:0];
    endfunction

    function automatic logic [31:0] taylor_step(logic [31:0] d, logic [31:0] n);
        longint a, b, q;
        logic [31:0] ta, tb;
        ta = d * 2 + rp_rem;
        tb = n * 4 + 1;
        a = longint'(signed'(ta));
        b = longint'(signed'(tb));
        q = a / b;
        rp_rem = 32'(a % b);
        return d - 32'(q);
    endfunction

    function automatic bit ramp_tick(output logic [31:0] load);
        logic [31:0] nd;
        bit st;
        nd = 0; st = 1; load = rp_delay;
        case (rp_phase)
            PH_STOP: begin
                rp_done = 0; rp_rem = 0; rp_tmr = 0; rp_drv = 0; st = 0;
            end
            PH_ACCEL: begin
                rp_done++; rp_count++;
                nd = taylor_step(rp_delay, rp_count);
                if (rp_done >= rp_dbegin) begin
                    rp_count = rp_dcount; rp_phase = PH_DECEL;
                end else if (nd <= rp_floor) begin
                    rp_cruise = nd; nd = rp_floor; rp_rem = 0; rp_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                rp_done++; nd = rp_floor;
                if (rp_done >= rp_dbegin) begin
                    rp_count = rp_dcount; nd = rp_cruise; rp_phase = PH_DECEL;
                end
            end
            default: begin
                rp_done++;
                nd = taylor_step(rp_delay, rp_count);
                rp_count++;
                if (!rp_count[31]) rp_phase = PH_STOP;
            end
        endcase
        rp_delay = nd;
        return st;
    endfunction

    function automatic t_out_word ramp_predict(t_in_word w);
        t_out_word r;
        logic [31:0] load, mag, acc, dec, spd;
        longint unsigned dv, alim, mlim;
        bit pulse, err;
        load = 0; err = 0; pulse = 0;
        acc = w.accel; dec = w.decel; spd = w.speed;
        if (w.cmd == CMD_MOVE) begin
            if (acc == 0 || dec == 0 || spd == 0) begin
                err = 1;
            end else begin
                rp_dir = w.steps[31];
                mag = w.steps[31] ? 32'd0 - w.steps : w.steps;
                rp_drv = 1;
                if (mag == 1) begin
                    rp_count = 32'hFFFF_FFFF; rp_phase = PH_DECEL; rp_delay = 1;
                    pulse = ramp_tick(load); rp_tmr = 1;
                end else if (mag != 0) begin
                    rp_floor = sat_u64(K_AT100 / spd);
                    rp_delay = sat_u64(K_TF148 * root_rounded(sat_u64(K_ASQ / acc)) / 100);
                    dv = K_A20000 * acc / 100;
                    mlim = (dv == 0) ? 64'hFFFF_FFFF : (64'(spd) * spd) / dv;
                    if (mlim == 0) mlim = 1;
                    alim = 64'(mag) * dec / (64'(acc) + dec);
                    if (alim == 0) alim = 1;
                    if (alim <= mlim) rp_dcount = alim[31:0] - mag;
                    else rp_dcount = 32'd0 - 32'(mlim * acc / dec);
                    if (rp_dcount == 0) rp_dcount = 32'hFFFF_FFFF;
                    rp_dbegin = mag + rp_dcount;
                    if (rp_delay <= rp_floor) begin
                        rp_delay = rp_floor; rp_phase = PH_RUN;
                    end else begin
                        rp_phase = PH_ACCEL;
                    end
                    rp_count = 0;
                    pulse = ramp_tick(load); rp_tmr = 1;
                end
            end
        end else if (w.cmd == CMD_TICK) begin
            pulse = ramp_tick(load);
        end else if (w.cmd == CMD_STOP) begin
            rp_phase = PH_STOP;
        end
        r.step_pulse = pulse; r.direction = rp_dir; r.timer_load = load;
        r.timer_running = rp_tmr; r.driver_enabled = rp_drv;
        r.ramp_phase = rp_phase; r.error = err;
        return r;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_words.push_back(ramp_predict(w));
        @(negedge i_clk);
    endtask

    function automatic t_in_word make_word(int unsigned c, int s, int unsigned a,
                                           int unsigned d, int unsigned v);
        t_in_word w;
        w.cmd = 2'(c); w.steps = s; w.accel = 16'(a); w.decel = 16'(d);
        w.speed = 16'(v);
        return w;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(make_word(CMD_TICK, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic test_directed();
        send_word(make_word(CMD_TICK, 0, 0, 0, 0));
        send_word(make_word(CMD_MOVE, 100, 0, 50, 50));
        send_word(make_word(CMD_MOVE, 100, 50, 0, 50));
        send_word(make_word(CMD_MOVE, 100, 50, 50, 0));
        send_word(make_word(CMD_MOVE, 0, 100, 100, 100));
        send_word(make_word(CMD_MOVE, 1, 100, 100, 100));
        send_ticks(2);
        send_word(make_word(CMD_MOVE, -1, 100, 100, 100));
        send_word(make_word(CMD_MOVE, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_ticks(3);
        send_word(make_word(CMD_STOP, 0, 0, 0, 0));
        send_ticks(2);
        send_word(make_word(CMD_MOVE, 32'h7FFF_FFFF, 1, 1, 1));
        send_ticks(2);
        send_word(make_word(CMD_MOVE, 10, 16'hFFFF, 1, 16'hFFFF));
        send_ticks(2);
        send_word(make_word(2'd3, -5, 1, 2, 3));
        send_word(make_word(CMD_STOP, 0, 0, 0, 0));
        send_ticks(1);
        wait_drained();
    endtask

    task automatic test_random_moves();
        int n, s;
        logic [1:0] c;
        n = 0;
        while (n < 2000) begin
            if ($urandom_range(0, 9) < 8) begin
                s = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 60);
                if ($urandom_range(0, 1)) s = -s;
                send_word(make_word(CMD_MOVE, s,
                    $urandom_range(0, 3) ? $urandom_range(1, 2000) : $urandom,
                    $urandom_range(0, 3) ? $urandom_range(1, 2000) : $urandom,
                    $urandom_range(0, 3) ? $urandom_range(1, 3000) : $urandom));
                n++;
                repeat ($urandom_range(0, 70)) begin
                    send_ticks(1);
                    n++;
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_word(make_word(CMD_STOP, $urandom, $urandom, $urandom, $urandom));
                    n++;
                end
            end else begin
                c = 2'($urandom);
                send_word(make_word(c, $urandom, $urandom, $urandom, $urandom));
                n++;
            end
            if (n > 1000 && n < 1100) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", o_out_word);
            end else begin
                e = expected_words.pop_front();
                if (e !== o_out_word) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %h got %h", e, o_out_word);
                end
            end
        end
    end

    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (o_out_valid && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rp_phase = PH_STOP;
        rp_dir = 0; rp_drv = 0; rp_tmr = 0;
        rp_delay = 0; rp_dbegin = 0; rp_dcount = 0; rp_floor = 0;
        rp_count = 0; rp_cruise = 0; rp_done = 0; rp_rem = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_moves();
        wait_drained();
        repeat (100) @(posedge i_clk);
        stim_done = 1'b1;
        if (errors == 0 && expected_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/slsr_pkg.sv
hw/rtl/slsr_div.sv
hw/rtl/slsr_sqrt.sv
hw/rtl/stepper_linear_speed_ramp.sv
tb/testbench.sv
